// ----- design/pgn_pkg.sv -----
`default_nettype none
package pgn_pkg;

   localparam int TABLE_AW  = 8;
   localparam int COORD_W   = 24;
   localparam int FRAC_W    = 12;
   localparam int GRAD_W    = 16;
   localparam int PERIOD_W  = 9;
   localparam int OCT_W     = 4;
   localparam int K_W       = 3;
   localparam int OUT_W     = 18;
   localparam int NOISE_W   = 21;
   localparam int ACC_W     = 24;
   localparam int MAX_OCT   = 8;
   localparam int PIPE_LAST = 12;

   typedef enum logic [1:0] {
      REQ_LOAD_PERM = 2'd0,
      REQ_LOAD_GRAD = 2'd1,
      REQ_EVAL      = 2'd2,
      REQ_NONE      = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      REG_PERIOD_X   = 2'd0,
      REG_PERIOD_Y   = 2'd1,
      REG_OCTAVES    = 2'd2,
      REG_TURBULENCE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [K_W-1:0] k;
      logic           first;
      logic           last;
      logic           dummy;
      logic           single;
   } tag_type;

endpackage
`default_nettype wire

// ----- design/pgn_ram.sv -----
`default_nettype none
module pgn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

// ----- design/periodic_gradient_noise_2d_core.sv -----
`default_nettype none
// 2D periodic Perlin noise. Load words fill the permutation and gradient tables; an entry must
// be loaded before any sample reads it. An evaluate word is split by an octave sequencer into
// one pass per octave, and one pass enters the 12-stage pipeline every cycle while the output
// is not stalled: a single-mode sample takes one pass, a turbulence sample takes
// max(1, min(octave_count, 8)) passes, and the result is registered after its last pass leaves
// the pipeline; a stalled output holds the whole pipeline. A load word is taken only once the
// pipeline holds no sample pass, so the table writes never overtake reads in flight.
// Registers must be written over the APB port while the block is idle; this is not enforced.
module periodic_gradient_noise_2d_core
   import pgn_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_type,
   input  wire logic [7:0]            req_table_index,
   input  wire logic [7:0]            req_perm_value,
   input  wire logic signed [15:0]    req_grad_x,
   input  wire logic signed [15:0]    req_grad_y,
   input  wire logic signed [23:0]    req_coord_x,
   input  wire logic signed [23:0]    req_coord_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [17:0]         rsp_noise_value,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [3:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   // configuration
   logic [PERIOD_W-1:0] period_x_ff, period_y_ff;
   logic [OCT_W-1:0]    octaves_ff;
   logic                turb_ff;
   reg_index_type       csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_x_ff <= 9'd256;
         period_y_ff <= 9'd256;
         octaves_ff  <= 4'd1;
         turb_ff     <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            REG_PERIOD_X:   period_x_ff <= csr_pwdata[PERIOD_W-1:0];
            REG_PERIOD_Y:   period_y_ff <= csr_pwdata[PERIOD_W-1:0];
            REG_OCTAVES:    octaves_ff  <= csr_pwdata[OCT_W-1:0];
            REG_TURBULENCE: turb_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_PERIOD_X:   csr_prdata = 32'(period_x_ff);
         REG_PERIOD_Y:   csr_prdata = 32'(period_y_ff);
         REG_OCTAVES:    csr_prdata = 32'(octaves_ff);
         REG_TURBULENCE: csr_prdata = 32'(turb_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic rsp_valid_ff;
   logic adv;
   logic vld_ff [1:PIPE_LAST];
   logic pipe_busy;

   assign adv = !rsp_valid_ff || rsp_ready;

   always_comb begin
      pipe_busy = 1'b0;
      for (int i = 1; i <= PIPE_LAST; i++) begin
         pipe_busy = pipe_busy | vld_ff[i];
      end
   end

   // octave sequencer
   logic                     busy_ff;
   logic [K_W-1:0]           k_ff, nlast_ff;
   logic                     dummy_ff, single_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic                     issue, issue_last, eval_acc, load_acc;
   req_kind_type             kind;
   logic [OCT_W-1:0]         ncap;

   assign kind       = req_kind_type'(req_type);
   assign issue      = adv && busy_ff;
   assign issue_last = k_ff == nlast_ff;
   assign ncap       = (octaves_ff > 4'(MAX_OCT)) ? 4'(MAX_OCT) : octaves_ff;

   always_comb begin
      case (kind)
         REQ_EVAL:                    req_ready = adv && (!busy_ff || issue_last);
         REQ_LOAD_PERM, REQ_LOAD_GRAD: req_ready = !busy_ff && !pipe_busy;
         default:                     req_ready = 1'b1;
      endcase
   end

   assign eval_acc = req_valid && req_ready && (kind == REQ_EVAL);
   assign load_acc = req_valid && req_ready && !busy_ff && !pipe_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         if (issue && issue_last) begin
            busy_ff <= eval_acc;
            k_ff    <= '0;
         end else if (issue) begin
            k_ff <= k_ff + 3'd1;
         end else if (eval_acc) begin
            busy_ff <= 1'b1;
            k_ff    <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eval_acc) begin
         x_ff      <= req_coord_x;
         y_ff      <= req_coord_y;
         single_ff <= !turb_ff;
         dummy_ff  <= turb_ff && (ncap == '0);
         nlast_ff  <= (!turb_ff || ncap == '0) ? '0 : K_W'(ncap - 4'd1);
      end
   end

   // tables
   logic perm_we, grad_we;
   logic [7:0]  perm_i, perm_j;
   logic [7:0]  h00, h10, h01, h11;
   logic [31:0] g00, g10, g01, g11;
   logic [7:0]  b0x_ff, b1x_ff, b0y_ff, b1y_ff;
   logic [7:0]  by0_ff, by1_ff;
   logic [7:0]  addr_i0, addr_j0, addr_i1, addr_j1;

   assign perm_we = load_acc && req_valid && (kind == REQ_LOAD_PERM);
   assign grad_we = load_acc && req_valid && (kind == REQ_LOAD_GRAD);
   // row cell indexes delayed one stage to line up with the first table read
   assign addr_i0 = perm_i + b0y_ff;
   assign addr_j0 = perm_j + b0y_ff;
   assign addr_i1 = perm_i + b1y_ff;
   assign addr_j1 = perm_j + b1y_ff;

   pgn_ram #(.WIDTH(8), .DEPTH(256)) u_perm_a (
      .clock, .wr_en(perm_we), .wr_addr(req_table_index), .wr_data(req_perm_value),
      .rd_en(adv), .rd_addr_a(b0x_ff), .rd_addr_b(b1x_ff),
      .rd_data_a(perm_i), .rd_data_b(perm_j)
   );
   pgn_ram #(.WIDTH(8), .DEPTH(256)) u_perm_b0 (
      .clock, .wr_en(perm_we), .wr_addr(req_table_index), .wr_data(req_perm_value),
      .rd_en(adv), .rd_addr_a(addr_i0), .rd_addr_b(addr_j0),
      .rd_data_a(h00), .rd_data_b(h10)
   );
   pgn_ram #(.WIDTH(8), .DEPTH(256)) u_perm_b1 (
      .clock, .wr_en(perm_we), .wr_addr(req_table_index), .wr_data(req_perm_value),
      .rd_en(adv), .rd_addr_a(addr_i1), .rd_addr_b(addr_j1),
      .rd_data_a(h01), .rd_data_b(h11)
   );
   pgn_ram #(.WIDTH(32), .DEPTH(256)) u_grad_0 (
      .clock, .wr_en(grad_we), .wr_addr(req_table_index), .wr_data({req_grad_y, req_grad_x}),
      .rd_en(adv), .rd_addr_a(h00), .rd_addr_b(h10),
      .rd_data_a(g00), .rd_data_b(g10)
   );
   pgn_ram #(.WIDTH(32), .DEPTH(256)) u_grad_1 (
      .clock, .wr_en(grad_we), .wr_addr(req_table_index), .wr_data({req_grad_y, req_grad_x}),
      .rd_en(adv), .rd_addr_a(h01), .rd_addr_b(h11),
      .rd_data_a(g01), .rd_data_b(g11)
   );

   // restoring remainder, four quotient bits a step
   function automatic logic [8:0] rem_step4(input logic [8:0] rem_in, input logic [3:0] bits,
                                            input logic [8:0] d);
      logic [8:0] r;
      r = rem_in;
      for (int b = 3; b >= 0; b--) begin
         r = {r[7:0], bits[b]};
         if (r >= d) begin
            r = r - d;
         end
      end
      return r;
   endfunction

   // stage 1: scale coordinates and periods by 2^k, split into cell and fraction
   logic [31:0] xs, ys;
   logic [8:0]  pxe, pye;
   logic [15:0] pxs, pys;
   logic [7:0]  mx_ff, my_ff;
   logic [8:0]  dx_ff [1:2];
   logic [8:0]  dy_ff [1:2];
   logic [FRAC_W-1:0] rx_ff [1:6];
   logic [FRAC_W-1:0] ry_ff [1:6];
   tag_type     tag_ff [1:PIPE_LAST];
   tag_type     tag_in;

   assign xs  = 32'(x_ff) << k_ff;
   assign ys  = 32'(y_ff) << k_ff;
   assign pxe = (period_x_ff == '0) ? 9'd256 : period_x_ff;
   assign pye = (period_y_ff == '0) ? 9'd256 : period_y_ff;
   assign pxs = 16'(pxe) << k_ff;
   assign pys = 16'(pye) << k_ff;

   always_comb begin
      tag_in.k      = k_ff;
      tag_in.first  = k_ff == '0;
      tag_in.last   = issue_last;
      tag_in.dummy  = dummy_ff;
      tag_in.single = single_ff;
   end

   // stage 2..3: period remainder and fade products
   logic [8:0]  remx_ff, remy_ff;
   logic [3:0]  mxlo_ff, mylo_ff;
   logic [23:0] rrx_ff, rry_ff;
   logic [37:0] numx_ff, numy_ff;
   logic [8:0]  b0x_w, b0y_w, nx_w, ny_w;
   logic [13:0] fx_w, fy_w;
   logic [12:0] sx_ff [4:8];
   logic [12:0] sy_ff [4:10];

   assign b0x_w = rem_step4(remx_ff, mxlo_ff, dx_ff[2]);
   assign b0y_w = rem_step4(remy_ff, mylo_ff, dy_ff[2]);
   assign nx_w  = b0x_w + 9'd1;
   assign ny_w  = b0y_w + 9'd1;
   assign fx_w  = 14'd12288 - {1'b0, rx_ff[2], 1'b0};
   assign fy_w  = 14'd12288 - {1'b0, ry_ff[2], 1'b0};

   // stages 7..12: dot products and blends
   logic signed [12:0] rx0, ry0, rx1, ry1;
   logic signed [28:0] p00x_ff, p00y_ff, p10x_ff, p10y_ff;
   logic signed [28:0] p01x_ff, p01y_ff, p11x_ff, p11y_ff;
   logic signed [29:0] c00_ff, c10_ff, c01_ff, c11_ff;
   logic signed [29:0] c00_9_ff, c01_9_ff;
   logic signed [44:0] pa_ff, pb_ff;
   logic signed [30:0] a_ff, b_ff, a11_ff;
   logic signed [45:0] pn_ff;
   logic signed [NOISE_W-1:0] noise_ff;
   logic signed [31:0] v12;

   assign rx0 = $signed({1'b0, rx_ff[6]});
   assign ry0 = $signed({1'b0, ry_ff[6]});
   assign rx1 = rx0 - 13'sd4096;
   assign ry1 = ry0 - 13'sd4096;
   assign v12 = 32'(a11_ff) + 32'((pn_ff + 46'sd2048) >>> 12);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= PIPE_LAST; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[1] <= busy_ff;
         for (int i = 2; i <= PIPE_LAST; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[1] <= tag_in;
         for (int i = 2; i <= PIPE_LAST; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         for (int i = 2; i <= 6; i++) begin
            rx_ff[i] <= rx_ff[i-1];
            ry_ff[i] <= ry_ff[i-1];
         end
         for (int i = 5; i <= 8; i++) begin
            sx_ff[i] <= sx_ff[i-1];
         end
         for (int i = 5; i <= 10; i++) begin
            sy_ff[i] <= sy_ff[i-1];
         end
         // s1
         mx_ff    <= xs[19:12];
         my_ff    <= ys[19:12];
         rx_ff[1] <= xs[11:0];
         ry_ff[1] <= ys[11:0];
         dx_ff[1] <= (pxs[15:8] != '0) ? 9'd256 : pxs[8:0];
         dy_ff[1] <= (pys[15:8] != '0) ? 9'd256 : pys[8:0];
         // s2
         remx_ff  <= rem_step4(9'd0, mx_ff[7:4], dx_ff[1]);
         remy_ff  <= rem_step4(9'd0, my_ff[7:4], dy_ff[1]);
         mxlo_ff  <= mx_ff[3:0];
         mylo_ff  <= my_ff[3:0];
         dx_ff[2] <= dx_ff[1];
         dy_ff[2] <= dy_ff[1];
         rrx_ff   <= 24'(rx_ff[1]) * 24'(rx_ff[1]);
         rry_ff   <= 24'(ry_ff[1]) * 24'(ry_ff[1]);
         // s3
         b0x_ff  <= b0x_w[7:0];
         b1x_ff  <= (nx_w == dx_ff[2]) ? 8'd0 : nx_w[7:0];
         by0_ff  <= b0y_w[7:0];
         by1_ff  <= (ny_w == dy_ff[2]) ? 8'd0 : ny_w[7:0];
         numx_ff <= 38'(rrx_ff) * 38'(fx_w);
         numy_ff <= 38'(rry_ff) * 38'(fy_w);
         // s4
         sx_ff[4] <= 13'((numx_ff + 38'd8388608) >> 24);
         sy_ff[4] <= 13'((numy_ff + 38'd8388608) >> 24);
         b0y_ff   <= by0_ff;
         b1y_ff   <= by1_ff;
         // s7
         p00x_ff <= $signed(g00[15:0])  * rx0;
         p00y_ff <= $signed(g00[31:16]) * ry0;
         p10x_ff <= $signed(g10[15:0])  * rx1;
         p10y_ff <= $signed(g10[31:16]) * ry0;
         p01x_ff <= $signed(g01[15:0])  * rx0;
         p01y_ff <= $signed(g01[31:16]) * ry1;
         p11x_ff <= $signed(g11[15:0])  * rx1;
         p11y_ff <= $signed(g11[31:16]) * ry1;
         // s8
         c00_ff <= 30'(p00x_ff) + 30'(p00y_ff);
         c10_ff <= 30'(p10x_ff) + 30'(p10y_ff);
         c01_ff <= 30'(p01x_ff) + 30'(p01y_ff);
         c11_ff <= 30'(p11x_ff) + 30'(p11y_ff);
         // s9
         pa_ff    <= 45'(31'(c10_ff) - 31'(c00_ff)) * 45'($signed({1'b0, sx_ff[8]}));
         pb_ff    <= 45'(31'(c11_ff) - 31'(c01_ff)) * 45'($signed({1'b0, sx_ff[8]}));
         c00_9_ff <= c00_ff;
         c01_9_ff <= c01_ff;
         // s10
         a_ff <= 31'(c00_9_ff) + 31'((pa_ff + 45'sd2048) >>> 12);
         b_ff <= 31'(c01_9_ff) + 31'((pb_ff + 45'sd2048) >>> 12);
         // s11
         pn_ff  <= 46'(32'(b_ff) - 32'(a_ff)) * 46'($signed({1'b0, sy_ff[10]}));
         a11_ff <= a_ff;
         // s12
         noise_ff <= NOISE_W'((v12 + 32'sd1024) >>> 11);
      end
   end

   // output stage: saturate or accumulate octaves
   logic [ACC_W-1:0]   acc_ff;
   logic [NOISE_W-1:0] mag;
   logic [ACC_W-1:0]   term, total;
   logic signed [OUT_W-1:0] rsp_value_ff, single_sat;
   tag_type            t12;

   assign t12   = tag_ff[PIPE_LAST];
   assign mag   = noise_ff[NOISE_W-1] ? NOISE_W'(-noise_ff) : NOISE_W'(noise_ff);
   assign term  = t12.dummy ? '0 : ACC_W'(mag >> t12.k);
   assign total = (t12.first ? '0 : acc_ff) + term;

   always_comb begin
      if (noise_ff > 21'sd131071) begin
         single_sat = 18'sd131071;
      end else if (noise_ff < -21'sd131072) begin
         single_sat = -18'sd131072;
      end else begin
         single_sat = OUT_W'(noise_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[PIPE_LAST] && t12.last;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && vld_ff[PIPE_LAST]) begin
         acc_ff <= total;
         if (t12.single) begin
            rsp_value_ff <= single_sat;
         end else if (total > ACC_W'(131071)) begin
            rsp_value_ff <= 18'sd131071;
         end else begin
            rsp_value_ff <= $signed(OUT_W'(total));
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

endmodule
`default_nettype wire
